/* hdl/bmc_pkg.sv */
`timescale 1ns / 1ps

package bmc_pkg;

    // Request codes carried in the command field req_type.
    localparam logic [1:0] REQ_DEVICE    = 2'd0;
    localparam logic [1:0] REQ_GROUP_END = 2'd1;
    localparam logic [1:0] REQ_FINISH    = 2'd2;

    // One command transfer.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] bandwidth;
        logic [15:0] price;
    } t_cmd;

    // One result transfer.
    typedef struct packed {
        logic        found;
        logic [11:0] best_bandwidth;
        logic [23:0] best_cost;
        logic [23:0] ratio_q12;
    } t_result;

endpackage

/* hdl/bmc_ram.sv */
`timescale 1ns / 1ps

module bmc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: a write takes the cycle, otherwise a registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/bottleneck_min_cost_dp.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// command   in         start high, busy low     i_cmd    (bmc_pkg::t_cmd)
// result    out        o_valid, one cycle       o_result (bmc_pkg::t_result)
//
// A first-group device reads, then may write its slot; a later-group device walks the
// table (read both layers, then write back into the other layer).
// A later group end clears the current layer.
// Finish scans the table (read, multiply, compare), passes one setup state,
// divides when an entry was found, then clears both layers; the result is
// presented in the first clearing cycle.
// After reset a clearing pass runs with busy high.
// The receiver cannot stall: o_valid is high for exactly one cycle per finish.

module bottleneck_min_cost_dp #(
    parameter int BW_SLOTS  = 4096,
    parameter int COST_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  bmc_pkg::t_cmd    i_cmd,
    output logic             busy,
    output logic             o_valid,
    output bmc_pkg::t_result o_result
);

    import bmc_pkg::*;

    localparam int BW_BITS   = $clog2(BW_SLOTS);
    localparam int DIV_STEPS = BW_BITS + 12;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);
    localparam int PROD_BITS = BW_BITS + COST_BITS;

    localparam logic [COST_BITS-1:0] COST_MARK = '1;
    localparam logic [COST_BITS-1:0] COST_MAX  = COST_MARK - 1'b1;
    localparam logic [BW_BITS-1:0]   LAST_K    = BW_BITS'(BW_SLOTS - 1);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_UPD_RD   = 11'b00000000100,
        S_UPD_WR   = 11'b00000001000,
        S_REL_RD   = 11'b00000010000,
        S_REL_WR   = 11'b00000100000,
        S_SCN_RD   = 11'b00001000000,
        S_SCN_MUL  = 11'b00010000000,
        S_SCN_CMP  = 11'b00100000000,
        S_DIV_INIT = 11'b01000000000,
        S_DIV      = 11'b10000000000
    } t_state;

    t_state                 r_state;
    logic                   r_sel;
    logic                   r_first;
    logic                   r_clr_both;
    logic [BW_BITS-1:0]     r_k;
    logic [BW_BITS-1:0]     r_bw;
    logic [15:0]            r_price;
    logic                   r_found;
    logic [BW_BITS-1:0]     r_best_bw;
    logic [COST_BITS-1:0]   r_best_c;
    logic                   r_hit;
    logic [COST_BITS-1:0]   r_c;
    logic [PROD_BITS-1:0]   r_lhs;
    logic [PROD_BITS-1:0]   r_rhs;
    logic [DIV_STEPS-1:0]   r_dvd;
    logic [COST_BITS-1:0]   r_rem;
    logic [COST_BITS-1:0]   r_div;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   accept;
    logic [BW_BITS-1:0]     bw_clamped;
    logic [BW_BITS-1:0]     tgt;
    logic [COST_BITS-1:0]   rd_a;
    logic [COST_BITS-1:0]   rd_b;
    logic [COST_BITS-1:0]   cur_d;
    logic [COST_BITS-1:0]   nxt_d;
    logic [COST_BITS:0]     price_ext;
    logic [COST_BITS-1:0]   price_sat;
    logic [COST_BITS:0]     sum;
    logic [COST_BITS-1:0]   cand;
    logic                   upd_we;
    logic                   rel_we;
    logic [COST_BITS-1:0]   wval;
    logic                   en_a, en_b, we_a, we_b;
    logic [BW_BITS-1:0]     addr_a, addr_b;
    logic [COST_BITS:0]     div_sh;
    logic                   div_q;
    logic [COST_BITS:0]     div_rem;
    logic                   last_k;

    assign accept = start && (r_state == S_IDLE);
    assign last_k = (r_k == LAST_K);

    // Bandwidths past the table land in the top slot.
    always_comb begin
        if (32'(i_cmd.bandwidth) > 32'(BW_SLOTS - 1)) begin
            bw_clamped = LAST_K;
        end else begin
            bw_clamped = BW_BITS'(i_cmd.bandwidth);
        end
    end

    assign tgt   = (r_k < r_bw) ? r_k : r_bw;
    assign cur_d = r_sel ? rd_b : rd_a;
    assign nxt_d = r_sel ? rd_a : rd_b;

    // Saturating price and sum, never reaching the unreached marker.
    assign price_ext = (COST_BITS + 1)'(r_price);
    assign price_sat = (price_ext > {1'b0, COST_MAX}) ? COST_MAX : COST_BITS'(price_ext);
    assign sum       = {1'b0, cur_d} + price_ext;
    assign cand      = (sum > {1'b0, COST_MAX}) ? COST_MAX : COST_BITS'(sum);

    assign upd_we = (r_state == S_UPD_WR) && (price_sat < cur_d);
    assign rel_we = (r_state == S_REL_WR) && (cur_d != COST_MARK) && (cand < nxt_d);
    assign wval   = (r_state == S_CLEAR) ? COST_MARK :
                    (r_state == S_UPD_WR) ? price_sat : cand;

    // Memory port steering; layer a is index 0 and current when r_sel is low.
    always_comb begin
        en_a   = 1'b0;
        en_b   = 1'b0;
        we_a   = 1'b0;
        we_b   = 1'b0;
        addr_a = r_k;
        addr_b = r_k;
        unique case (r_state)
            S_CLEAR: begin
                we_a = r_clr_both || !r_sel;
                we_b = r_clr_both || r_sel;
            end
            S_UPD_RD: begin
                addr_a = r_bw;
                addr_b = r_bw;
                en_a   = !r_sel;
                en_b   = r_sel;
            end
            S_UPD_WR: begin
                addr_a = r_bw;
                addr_b = r_bw;
                we_a   = upd_we && !r_sel;
                we_b   = upd_we && r_sel;
            end
            S_REL_RD: begin
                addr_a = r_sel ? tgt : r_k;
                addr_b = r_sel ? r_k : tgt;
                en_a   = 1'b1;
                en_b   = 1'b1;
            end
            S_REL_WR: begin
                addr_a = tgt;
                addr_b = tgt;
                we_a   = rel_we && r_sel;
                we_b   = rel_we && !r_sel;
            end
            S_SCN_RD: begin
                en_a = !r_sel;
                en_b = r_sel;
            end
            default: begin
            end
        endcase
    end

    bmc_ram #(.WIDTH(COST_BITS), .DEPTH(BW_SLOTS)) u_layer_a (
        .i_clk   (i_clk),
        .i_en    (en_a),
        .i_we    (we_a),
        .i_addr  (addr_a),
        .i_wdata (wval),
        .o_rdata (rd_a)
    );

    bmc_ram #(.WIDTH(COST_BITS), .DEPTH(BW_SLOTS)) u_layer_b (
        .i_clk   (i_clk),
        .i_en    (en_b),
        .i_we    (we_b),
        .i_addr  (addr_b),
        .i_wdata (wval),
        .o_rdata (rd_b)
    );

    // One restoring division step.
    assign div_sh  = {r_rem, r_dvd[DIV_STEPS-1]};
    assign div_q   = (div_sh >= {1'b0, r_div});
    assign div_rem = div_q ? (div_sh - {1'b0, r_div}) : div_sh;

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        r_out_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_both  <= 1'b1;
            r_k         <= '0;
            r_sel       <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_k <= r_k + 1'b1;
                    if (last_k) begin
                        r_k     <= '0;
                        r_state <= S_IDLE;
                        if (r_clr_both) begin
                            r_sel   <= 1'b0;
                            r_first <= 1'b1;
                        end else begin
                            r_sel <= !r_sel;
                        end
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_bw    <= bw_clamped;
                        r_price <= i_cmd.price;
                        r_k     <= '0;
                        unique case (i_cmd.req_type)
                            REQ_DEVICE: begin
                                r_state <= r_first ? S_UPD_RD : S_REL_RD;
                            end
                            REQ_GROUP_END: begin
                                if (r_first) begin
                                    r_first <= 1'b0;
                                end else begin
                                    r_clr_both <= 1'b0;
                                    r_state    <= S_CLEAR;
                                end
                            end
                            REQ_FINISH: begin
                                r_found <= 1'b0;
                                r_best_bw <= '0;
                                r_best_c  <= '0;
                                r_state   <= S_SCN_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_UPD_RD: r_state <= S_UPD_WR;
                S_UPD_WR: r_state <= S_IDLE;
                S_REL_RD: r_state <= S_REL_WR;
                S_REL_WR: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= last_k ? S_IDLE : S_REL_RD;
                end
                S_SCN_RD: r_state <= S_SCN_MUL;
                S_SCN_MUL: begin
                    r_hit   <= (cur_d != COST_MARK);
                    r_c     <= cur_d;
                    r_lhs   <= PROD_BITS'(r_k) * PROD_BITS'(r_best_c);
                    r_rhs   <= PROD_BITS'(r_best_bw) * PROD_BITS'(cur_d);
                    r_state <= S_SCN_CMP;
                end
                S_SCN_CMP: begin
                    if (r_hit && (!r_found || (r_lhs > r_rhs))) begin
                        r_found   <= 1'b1;
                        r_best_bw <= r_k;
                        r_best_c  <= r_c;
                    end
                    r_k     <= r_k + 1'b1;
                    r_state <= last_k ? S_DIV_INIT : S_SCN_RD;
                end
                S_DIV_INIT: begin
                    r_k <= '0;
                    if (r_found) begin
                        r_dvd   <= {r_best_bw, 12'd0};
                        r_rem   <= '0;
                        r_div   <= (r_best_c == '0) ? COST_BITS'(1) : r_best_c;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_out       <= '0;
                        r_out_valid <= 1'b1;
                        r_clr_both  <= 1'b1;
                        r_state     <= S_CLEAR;
                    end
                end
                S_DIV: begin
                    r_rem <= COST_BITS'(div_rem);
                    r_dvd <= {r_dvd[DIV_STEPS-2:0], div_q};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                        r_out.found          <= 1'b1;
                        r_out.best_bandwidth <= 12'(r_best_bw);
                        r_out.best_cost      <= 24'(r_best_c);
                        r_out.ratio_q12      <= 24'({r_dvd[DIV_STEPS-2:0], div_q});
                        r_out_valid          <= 1'b1;
                        r_clr_both           <= 1'b1;
                        r_state              <= S_CLEAR;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // A result is always followed by the clearing pass.
    a_valid_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_CLEAR) && r_clr_both)
        else $error("result not followed by table clear");

    // An empty table reports all zero fields.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.found) |-> (o_result.ratio_q12 == '0) &&
        (o_result.best_cost == '0) && (o_result.best_bandwidth == '0))
        else $error("empty result carries nonzero fields");

    // Both layers are written together only by the full clear.
    a_dual_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we_a && we_b) |-> (r_state == S_CLEAR) && r_clr_both)
        else $error("both layers written outside full clear");

    // Relaxation never writes into the current layer.
    a_rel_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL_WR) |-> !(r_sel ? we_b : we_a))
        else $error("relaxation wrote the current layer");

endmodule
